// File: sv/tsfs_pkg.sv
// ----------------------------------------------------------------------------
// tsfs_pkg
// Shared types and constants of the tempo-synced frame stepper.
// ----------------------------------------------------------------------------
package tsfs_pkg;

  localparam int MAX_FRAMES = 1024;
  localparam int FRAME_W    = 10;
  localparam int COUNT_W    = 11;
  localparam int PPQ_W      = 48;
  localparam int BLOCK_W    = 14;
  localparam int SIG_W      = 6;
  localparam int SPEED_W    = 3;
  localparam int RATE_W     = 18;
  localparam int ACC_W      = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Shared divider: unsigned dividend and divisor widths, one bit per cycle
  localparam int DIV_NUM_W  = 40;
  localparam int DIV_DEN_W  = 24;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED       = 3'd0,
    REG_SYNC_MODE   = 3'd1,
    REG_SYNC_UNIT   = 3'd2,
    REG_FRAME_COUNT = 3'd3,
    REG_SAMPLE_RATE = 3'd4
  } cfg_reg_t;

  // Speed codes
  localparam logic [SPEED_W-1:0] SPEED_QUARTER = 3'd0;
  localparam logic [SPEED_W-1:0] SPEED_HALF    = 3'd1;
  localparam logic [SPEED_W-1:0] SPEED_DOUBLE  = 3'd3;
  localparam logic [SPEED_W-1:0] SPEED_QUAD    = 3'd4;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_BEAT_DIV,
    S_BEAT_FIN,
    S_BAR_MUL,
    S_BAR_IDX,
    S_BAR_BI,
    S_BAR_MULB,
    S_BAR_X,
    S_BAR_R,
    S_BAR_F,
    S_BAR_FIN,
    S_FREE_ACC,
    S_FREE_STEP,
    S_FREE_FIN,
    S_WAIT,
    S_WRITE
  } seq_state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
    logic [DIV_DEN_W-1:0] remainder;
  } div_rsp_t;

  // log2 of speed*4; unknown codes run at 1x
  function automatic logic [2:0] speed_shift(input logic [SPEED_W-1:0] code);
    logic [2:0] s;
    case (code)
      SPEED_QUARTER: s = 3'd0;
      SPEED_HALF:    s = 3'd1;
      SPEED_DOUBLE:  s = 3'd3;
      SPEED_QUAD:    s = 3'd4;
      default:       s = 3'd2;
    endcase
    return s;
  endfunction

endpackage

// File: sv/tsfs_ifs.sv
// ----------------------------------------------------------------------------
// tsfs channel interfaces
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tsfs_in_if import tsfs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [BLOCK_W-1:0]      block_samples;
  logic                    position_valid;
  logic                    is_playing;
  logic signed [PPQ_W-1:0] ppq_position;
  logic                    sig_valid;
  logic [SIG_W-1:0]        sig_numerator;
  logic [SIG_W-1:0]        sig_denominator;
  logic                    bar_start_valid;
  logic signed [PPQ_W-1:0] bar_start_ppq;

  modport source (output valid, block_samples, position_valid, is_playing, ppq_position,
                  sig_valid, sig_numerator, sig_denominator, bar_start_valid,
                  bar_start_ppq, input ready);
  modport sink (input valid, block_samples, position_valid, is_playing, ppq_position,
                sig_valid, sig_numerator, sig_denominator, bar_start_valid,
                bar_start_ppq, output ready);
endinterface

interface tsfs_out_if import tsfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_index;

  modport source (output valid, frame_index, input ready);
  modport sink (input valid, frame_index, output ready);
endinterface

interface tsfs_cfg_if import tsfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/tempo_synced_frame_stepper.sv
// ----------------------------------------------------------------------------
// tempo_synced_frame_stepper
// Picks the animation frame for each audio block from host position or a
// free-running sample accumulator. All divisions run on one shared divider.
// ----------------------------------------------------------------------------
// The sequencer runs the shared divider once in beat mode, twice in free-run
// mode and three times in bar mode; a held frame skips it. A stalled result
// holds up the next word. One word at a time: the next word is taken the
// cycle after the result is registered. Reset (synchronous, rst high)
// restores the register defaults, clears the frame and the accumulator and
// leaves the block ready.
module tempo_synced_frame_stepper import tsfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tsfs_in_if.sink     in_ch,
  tsfs_out_if.source  out_ch,
  tsfs_cfg_if.sink    cfg
);

  // Configuration and state
  logic [SPEED_W-1:0] speed_code;
  logic               sync_mode;
  logic               sync_unit;
  logic [COUNT_W-1:0] frame_count;
  logic [RATE_W-1:0]  sample_rate;
  logic [FRAME_W-1:0] current_frame;
  logic [ACC_W-1:0]   sample_accumulator;

  // Sequencer
  seq_state_t state, state_next;
  seq_state_t ret_state, ret_next;

  // Latched input word
  logic [BLOCK_W-1:0]      blk;
  logic                    pos_ok;
  logic                    playing;
  logic signed [PPQ_W-1:0] ppq;
  logic [SIG_W-1:0]        num;
  logic [SIG_W-1:0]        den;
  logic                    bar_ok;
  logic signed [PPQ_W-1:0] bar_ppq;

  // Work registers
  logic signed [54:0] pd;
  logic signed [55:0] nraw;
  logic signed [37:0] bar_index;
  logic signed [44:0] bi_num;
  logic [19:0]        lo;
  logic               neg;
  logic [36:0]        prod;

  // Output register
  logic               out_valid;
  logic [FRAME_W-1:0] out_frame;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tsfs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Derived values
  logic [COUNT_W-1:0]   count_eff;
  logic [2:0]           s;
  logic signed [51:0]   pq_w;
  logic signed [35:0]   beat_v;
  logic [35:0]          beat_mag;
  logic signed [36:0]   pd_hi;
  logic [36:0]          pd_mag;
  logic [37:0]          q_adj;
  logic [23:0]          d_val;
  logic signed [55:0]   d_s;
  logic signed [55:0]   n_clamp;
  logic signed [62:0]   bar_y;
  logic signed [66:0]   bar_x;
  logic signed [46:0]   bar_hi;
  logic [46:0]          hi_mag;
  logic [SIG_W-1:0]     num_rem;
  logic [SIG_W-1:0]     bar_m;
  logic [25:0]          bar_r;
  logic [ACC_W-1:0]     acc_sum;
  logic [DIV_DEN_W-1:0] interval;
  logic [COUNT_W-1:0]   beat_rem;
  logic [COUNT_W-1:0]   beat_frame;
  logic [COUNT_W-1:0]   free_sum;
  logic [COUNT_W-1:0]   free_frame;

  always_comb begin
    count_eff = (frame_count > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES) : frame_count;
    s         = speed_shift(speed_code);

    // Beat position: floor(ppq * speed * 4 / 2^16)
    pq_w     = $signed({{4{ppq[PPQ_W-1]}}, ppq}) <<< s;
    beat_v   = pq_w[51:16];
    beat_mag = beat_v[35] ? 36'(-beat_v) : 36'(beat_v);

    // Bar index dividend: floor(ppq * den / 2^18)
    pd_hi  = pd[54:18];
    pd_mag = pd_hi[36] ? 37'(-pd_hi) : 37'(pd_hi);
    q_adj  = {1'b0, div_rsp.quotient[36:0]} + 38'(div_rsp.remainder != '0);

    // Loop position within four bars
    d_val   = {num, 18'd0};
    d_s     = $signed({32'd0, d_val});
    n_clamp = nraw[55] ? 56'sd0 : ((nraw > d_s) ? d_s : nraw);
    bar_y   = bar_ok ? ($signed({bi_num, 18'd0}) + n_clamp) : 63'(pd);
    bar_x   = $signed({{4{bar_y[62]}}, bar_y}) <<< s;
    bar_hi  = bar_x[66:20];
    hi_mag  = bar_hi[46] ? 47'(-bar_hi) : 47'(bar_hi);
    num_rem = div_rsp.remainder[SIG_W-1:0];
    bar_m   = (neg && num_rem != '0) ? (num - num_rem) : num_rem;
    bar_r   = {bar_m, lo};

    // Free run
    acc_sum  = sample_accumulator + ACC_W'(blk) * ACC_W'(160);
    interval = (sample_rate == '0) ? DIV_DEN_W'(1)
                                   : (DIV_DEN_W'(sample_rate) << (3'd6 - s));

    beat_rem   = div_rsp.remainder[COUNT_W-1:0];
    beat_frame = (neg && beat_rem != '0) ? (count_eff - beat_rem) : beat_rem;
    free_sum   = {1'b0, current_frame} + div_rsp.remainder[COUNT_W-1:0];
    free_frame = (free_sum >= count_eff) ? (free_sum - count_eff) : free_sum;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
    end else begin
      state     <= state_next;
      ret_state <= ret_next;
    end
  end

  // Next state and divider requests
  always_comb begin
    state_next       = state;
    ret_next         = ret_state;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = DIV_DEN_W'(1);
    case (state)
      S_IDLE: begin
        if (in_ch.valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (count_eff == '0) state_next = S_WRITE;
        else if (sync_mode) begin
          if (!(pos_ok && playing)) state_next = S_WRITE;
          else if (sync_unit) state_next = S_BAR_MUL;
          else state_next = S_BEAT_DIV;
        end else state_next = S_FREE_ACC;
      end
      S_BEAT_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NUM_W'(beat_mag);
        div_req.divisor  = DIV_DEN_W'(count_eff);
        state_next       = S_WAIT;
        ret_next         = S_BEAT_FIN;
      end
      S_BEAT_FIN: state_next = S_WRITE;
      S_BAR_MUL:  state_next = S_BAR_IDX;
      S_BAR_IDX: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NUM_W'(pd_mag);
        div_req.divisor  = DIV_DEN_W'(num);
        state_next       = S_WAIT;
        ret_next         = S_BAR_BI;
      end
      S_BAR_BI:   state_next = S_BAR_MULB;
      S_BAR_MULB: state_next = S_BAR_X;
      S_BAR_X: begin
        div_req.start    = 1'b1;
        div_req.dividend = hi_mag[DIV_NUM_W-1:0];
        div_req.divisor  = DIV_DEN_W'(num);
        state_next       = S_WAIT;
        ret_next         = S_BAR_R;
      end
      S_BAR_R: state_next = S_BAR_F;
      S_BAR_F: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NUM_W'(prod[36:20]);
        div_req.divisor  = DIV_DEN_W'(num);
        state_next       = S_WAIT;
        ret_next         = S_BAR_FIN;
      end
      S_BAR_FIN: state_next = S_WRITE;
      S_FREE_ACC: begin
        div_req.start    = 1'b1;
        div_req.dividend = acc_sum;
        div_req.divisor  = interval;
        state_next       = S_WAIT;
        ret_next         = S_FREE_STEP;
      end
      S_FREE_STEP: begin
        div_req.start    = 1'b1;
        div_req.dividend = div_rsp.quotient;
        div_req.divisor  = DIV_DEN_W'(count_eff);
        state_next       = S_WAIT;
        ret_next         = S_FREE_FIN;
      end
      S_FREE_FIN: state_next = S_WRITE;
      S_WAIT: begin
        if (div_rsp.done) state_next = ret_state;
      end
      S_WRITE: begin
        if (!out_valid || out_ch.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Latch the input word and run the datapath steps
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          blk     <= in_ch.block_samples;
          pos_ok  <= in_ch.position_valid;
          playing <= in_ch.is_playing;
          ppq     <= in_ch.ppq_position;
          bar_ok  <= in_ch.bar_start_valid;
          bar_ppq <= in_ch.bar_start_ppq;
          // Missing or zero signature falls back to 4/4
          if (!in_ch.sig_valid || in_ch.sig_numerator == '0 || in_ch.sig_denominator == '0)
          begin
            num <= SIG_W'(4);
            den <= SIG_W'(4);
          end else begin
            num <= in_ch.sig_numerator;
            den <= in_ch.sig_denominator;
          end
        end
      end
      S_BEAT_DIV: neg <= beat_v[35];
      S_BAR_MUL: begin
        pd   <= ppq * $signed({1'b0, den});
        nraw <= (ppq - bar_ppq) * $signed({1'b0, den});
      end
      S_BAR_IDX:  neg <= pd_hi[36];
      // Floor division: round the magnitude up only for a negative dividend
      S_BAR_BI:   bar_index <= neg ? -$signed(q_adj)
                                   : $signed({1'b0, div_rsp.quotient[36:0]});
      S_BAR_MULB: bi_num <= bar_index * $signed({1'b0, num});
      S_BAR_X: begin
        neg <= bar_hi[46];
        lo  <= bar_x[19:0];
      end
      S_BAR_R: prod <= 37'(bar_r) * 37'(count_eff);
      default: ;
    endcase
  end

  // Frame, accumulator and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_code         <= SPEED_W'(2);
      sync_mode          <= 1'b1;
      sync_unit          <= 1'b0;
      frame_count        <= '0;
      sample_rate        <= RATE_W'(48000);
      current_frame      <= '0;
      sample_accumulator <= '0;
    end else begin
      case (state)
        S_BEAT_FIN:  current_frame <= beat_frame[FRAME_W-1:0];
        S_BAR_FIN:   current_frame <= div_rsp.quotient[FRAME_W-1:0];
        S_FREE_STEP: sample_accumulator <= ACC_W'(div_rsp.remainder);
        S_FREE_FIN:  current_frame <= free_frame[FRAME_W-1:0];
        default: ;
      endcase
      if (cfg.valid) begin
        case (cfg_reg_t'(cfg.index))
          REG_SPEED:     speed_code <= cfg.data[SPEED_W-1:0];
          REG_SYNC_MODE: sync_mode  <= cfg.data[0];
          REG_SYNC_UNIT: sync_unit  <= cfg.data[0];
          REG_FRAME_COUNT: begin
            frame_count   <= cfg.data[COUNT_W-1:0];
            current_frame <= '0;
          end
          REG_SAMPLE_RATE: begin
            sample_rate        <= cfg.data[RATE_W-1:0];
            sample_accumulator <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_WRITE && (!out_valid || out_ch.ready)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE && (!out_valid || out_ch.ready)) out_frame <= current_frame;
  end

  assign in_ch.ready        = (state == S_IDLE);
  assign cfg.ready          = 1'b1;
  assign out_ch.valid       = out_valid;
  assign out_ch.frame_index = out_frame;

endmodule

// File: sv/tsfs_div.sv
// ----------------------------------------------------------------------------
// tsfs_div
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsfs_div import tsfs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem, quo[DIV_NUM_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  // Control: stays busy until every dividend bit has been shifted through
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift quotient bits in, keep the remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// File: sv/tsfs_checker.sv
// ----------------------------------------------------------------------------
// tsfs_checker
// Port-level checks of the frame stepper, bound to the top level.
// ----------------------------------------------------------------------------
module tsfs_checker import tsfs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FRAME_W-1:0] frame_index
);

  // Busy after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while previous word in progress");

  // No result in the cycle right after a word is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(frame_index)))
    else $error("stalled result changed");

  // Reset leaves the block ready and empty
  a_reset_state: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

endmodule

bind tempo_synced_frame_stepper tsfs_checker u_tsfs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .frame_index (out_ch.frame_index)
);

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tempo-synced frame stepper: a queue-fed driver,
// a result monitor and a scoreboard model of the frame stepping, run over a
// series of register settings and three backpressure profiles.
// ----------------------------------------------------------------------------
module tb;
  import tsfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [BLOCK_W-1:0]      block_samples;
    logic                    position_valid;
    logic                    is_playing;
    logic signed [PPQ_W-1:0] ppq_position;
    logic                    sig_valid;
    logic [SIG_W-1:0]        sig_numerator;
    logic [SIG_W-1:0]        sig_denominator;
    logic                    bar_start_valid;
    logic signed [PPQ_W-1:0] bar_start_ppq;
  } block_word_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tsfs_in_if  in_ch ();
  tsfs_out_if out_ch ();
  tsfs_cfg_if cfg ();

  tempo_synced_frame_stepper u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  // Model of the register file and the stepping state
  logic [SPEED_W-1:0] m_speed = 3'd2;
  logic               m_sync_mode = 1'b1;
  logic               m_sync_unit = 1'b0;
  logic [COUNT_W-1:0] m_count = '0;
  logic [RATE_W-1:0]  m_rate = 18'd48000;
  logic [FRAME_W-1:0] m_frame = '0;
  longint             m_acc = 0;

  block_word_t        pending_words[$];
  logic [FRAME_W-1:0] expected_frames[$];
  block_word_t        cur_word;
  bit                 word_taken = 0;
  int                 src_idle = 0;
  int                 snk_idle = 0;
  int                 mismatches = 0;
  int                 quiet_cycles = 0;

  // Clock and one reset at the start
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint emod(longint a, longint b);
    longint r;
    r = a % b;
    if (r < 0) r = r + b;
    return r;
  endfunction

  // Advance the model by one audio block and return the frame shown
  function automatic logic [FRAME_W-1:0] step_frame(block_word_t w);
    longint cnt, q, num, den, p, b, d, pd, bi, n, x, r, interval, steps;
    cnt = m_count;
    if (cnt > MAX_FRAMES) cnt = MAX_FRAMES;
    case (m_speed)
      SPEED_QUARTER: q = 1;
      SPEED_HALF:    q = 2;
      SPEED_DOUBLE:  q = 8;
      SPEED_QUAD:    q = 16;
      default:       q = 4;
    endcase
    p = longint'(w.ppq_position);
    b = longint'(w.bar_start_ppq);
    num = w.sig_numerator;
    den = w.sig_denominator;
    if (cnt > 0) begin
      if (m_sync_mode) begin
        if (w.position_valid && w.is_playing) begin
          if (m_sync_unit) begin
            if (!w.sig_valid || num == 0 || den == 0) begin
              num = 4;
              den = 4;
            end
            d = 4 * num * 65536;
            pd = p * den;
            bi = fdiv(pd, d);
            if (w.bar_start_valid) begin
              n = (p - b) * den;
              if (n < 0) n = 0;
              if (n > d) n = d;
            end else begin
              n = pd - bi * d;
            end
            x = (bi * d + n) * q;
            r = emod(x, 4 * d);
            m_frame = FRAME_W'((r * cnt) / (4 * d));
          end else begin
            m_frame = FRAME_W'(emod(fdiv(p * q, 65536), cnt));
          end
        end
      end else begin
        interval = (longint'(m_rate) * 64) / q;
        if (interval == 0) interval = 1;
        m_acc = m_acc + longint'(w.block_samples) * 160;
        steps = m_acc / interval;
        m_acc = m_acc - steps * interval;
        m_frame = FRAME_W'(((longint'(m_frame) % cnt) + steps % cnt) % cnt);
      end
    end
    return m_frame;
  endfunction

  function automatic block_word_t mk_word(int blk, bit pv, bit pl, longint p, bit sv,
                                          int num, int den, bit bv, longint b);
    block_word_t w;
    w.block_samples   = BLOCK_W'(blk);
    w.position_valid  = pv;
    w.is_playing      = pl;
    w.ppq_position    = PPQ_W'(p);
    w.sig_valid       = sv;
    w.sig_numerator   = SIG_W'(num);
    w.sig_denominator = SIG_W'(den);
    w.bar_start_valid = bv;
    w.bar_start_ppq   = PPQ_W'(b);
    return w;
  endfunction

  function automatic block_word_t rand_word();
    block_word_t w;
    longint span;
    w.block_samples = ($urandom_range(9) == 0) ? BLOCK_W'($urandom)
                                               : BLOCK_W'($urandom_range(8192));
    w.position_valid = ($urandom_range(9) != 0);
    w.is_playing     = ($urandom_range(9) != 0);
    if ($urandom_range(3) == 0)
      w.ppq_position = PPQ_W'({$urandom, $urandom});
    else
      w.ppq_position = PPQ_W'(longint'($urandom_range(1 << 25)) - (1 << 24));
    w.sig_valid = ($urandom_range(7) != 0);
    if ($urandom_range(7) == 0) begin
      w.sig_numerator   = SIG_W'($urandom);
      w.sig_denominator = SIG_W'($urandom);
    end else begin
      w.sig_numerator   = SIG_W'($urandom_range(32, 1));
      w.sig_denominator = SIG_W'($urandom_range(32, 1));
    end
    w.bar_start_valid = ($urandom_range(2) != 0);
    // Mostly a bar start just behind the position, sometimes anywhere
    span = longint'($urandom_range(1 << 22)) - (1 << 18);
    if ($urandom_range(5) == 0)
      w.bar_start_ppq = PPQ_W'({$urandom, $urandom});
    else
      w.bar_start_ppq = PPQ_W'(longint'(w.ppq_position) - span);
    return w;
  endfunction

  // Input driver: change at the falling edge, hold until taken
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || word_taken) begin
      word_taken = 0;
      if (pending_words.size() > 0 && $urandom_range(99) >= src_idle) begin
        cur_word = pending_words.pop_front();
        in_ch.block_samples   <= cur_word.block_samples;
        in_ch.position_valid  <= cur_word.position_valid;
        in_ch.is_playing      <= cur_word.is_playing;
        in_ch.ppq_position    <= cur_word.ppq_position;
        in_ch.sig_valid       <= cur_word.sig_valid;
        in_ch.sig_numerator   <= cur_word.sig_numerator;
        in_ch.sig_denominator <= cur_word.sig_denominator;
        in_ch.bar_start_valid <= cur_word.bar_start_valid;
        in_ch.bar_start_ppq   <= cur_word.bar_start_ppq;
        in_ch.valid           <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready with random stalls
  always @(negedge clk) begin
    out_ch.ready <= (rst) ? 1'b0 : ($urandom_range(99) >= snk_idle);
  end

  // Predict on accept, compare on result, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles = quiet_cycles + 1;
      if (in_ch.valid && in_ch.ready) begin
        expected_frames.push_back(step_frame(cur_word));
        word_taken = 1;
        quiet_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles = 0;
        if (expected_frames.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("tb: unexpected frame_index %0d", out_ch.frame_index);
        end else begin
          if (out_ch.frame_index !== expected_frames[0]) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("tb: frame_index expected %0d actual %0d",
                       expected_frames[0], out_ch.frame_index);
          end
          void'(expected_frames.pop_front());
        end
      end
      if (cfg.valid && cfg.ready) quiet_cycles = 0;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Write one register through the configuration channel and mirror it in the model
  task automatic write_reg(cfg_reg_t idx, int value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_SPEED:       m_speed = SPEED_W'(value);
      REG_SYNC_MODE:   m_sync_mode = value[0];
      REG_SYNC_UNIT:   m_sync_unit = value[0];
      REG_FRAME_COUNT: begin
        m_count = COUNT_W'(value);
        m_frame = '0;
      end
      REG_SAMPLE_RATE: begin
        m_rate = RATE_W'(value);
        m_acc = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Hold until all words are through, then let the block settle
  task automatic drain();
    while (pending_words.size() > 0 || in_ch.valid || expected_frames.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_all(int spd, int mode, int unit, int cnt, int rate);
    write_reg(REG_SPEED, spd);
    write_reg(REG_SYNC_MODE, mode);
    write_reg(REG_SYNC_UNIT, unit);
    write_reg(REG_FRAME_COUNT, cnt);
    write_reg(REG_SAMPLE_RATE, rate);
  endtask

  initial begin
    int cnt_pick[6];
    int rate_pick[5];
    longint pmax, pmin;
    pmax = (longint'(1) << 47) - 1;
    pmin = -(longint'(1) << 47);
    in_ch.valid = 1'b0;
    in_ch.block_samples = '0;
    in_ch.position_valid = 1'b0;
    in_ch.is_playing = 1'b0;
    in_ch.ppq_position = '0;
    in_ch.sig_valid = 1'b0;
    in_ch.sig_numerator = '0;
    in_ch.sig_denominator = '0;
    in_ch.bar_start_valid = 1'b0;
    in_ch.bar_start_ppq = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    @(negedge rst);
    src_idle = 6;
    snk_idle = 55;

    // Count zero after reset: the frame holds
    pending_words.push_back(mk_word(8192, 1, 1, pmax, 1, 32, 32, 1, pmin));
    pending_words.push_back(mk_word(0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Beat mode at the ppq extremes, with no position and with transport stopped
    set_all(4, 1, 0, 1024, 48000);
    pending_words.push_back(mk_word(1, 1, 1, pmax, 0, 0, 0, 0, 0));
    pending_words.push_back(mk_word(1, 1, 1, pmin, 0, 0, 0, 0, 0));
    pending_words.push_back(mk_word(1, 1, 1, -1, 0, 0, 0, 0, 0));
    pending_words.push_back(mk_word(1, 0, 1, 65536, 0, 0, 0, 0, 0));
    pending_words.push_back(mk_word(1, 1, 0, 65536, 0, 0, 0, 0, 0));
    drain();

    // Bar mode: missing and zero signature, bar start ahead, far behind, absent
    set_all(7, 1, 1, 2047, 48000);
    pending_words.push_back(mk_word(0, 1, 1, 300000, 0, 3, 8, 0, 0));
    pending_words.push_back(mk_word(0, 1, 1, 300000, 1, 0, 8, 0, 0));
    pending_words.push_back(mk_word(0, 1, 1, 300000, 1, 7, 0, 0, 0));
    pending_words.push_back(mk_word(0, 1, 1, 300000, 1, 63, 63, 1, 400000));
    pending_words.push_back(mk_word(0, 1, 1, 300000, 1, 32, 1, 1, pmin));
    pending_words.push_back(mk_word(0, 1, 1, pmax, 1, 1, 32, 1, pmax));
    pending_words.push_back(mk_word(0, 1, 1, pmin, 1, 5, 16, 0, 0));
    drain();

    // Free run: zero rate, then the top rate at quarter speed, count one
    set_all(2, 0, 0, 7, 0);
    pending_words.push_back(mk_word(3, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(mk_word(16383, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();
    set_all(0, 0, 1, 1, 262143);
    pending_words.push_back(mk_word(8192, 1, 1, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(mk_word(16383, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(mk_word(0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Random phases over random settings and three stall profiles
    cnt_pick = '{0, 1, 2, 1024, 2047, 0};
    rate_pick = '{0, 8000, 192000, 262143, 48000};
    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 5) begin
        src_idle = 55;
        snk_idle = 6;
      end else if (ph == 10) begin
        src_idle = 0;
        snk_idle = 0;
      end
      cnt_pick[5] = $urandom_range(1023, 3);
      set_all($urandom_range(7), (ph % 3 == 2) ? 0 : 1, $urandom_range(1),
              ($urandom_range(3) == 0) ? cnt_pick[$urandom_range(5)] : cnt_pick[5],
              ($urandom_range(2) == 0) ? rate_pick[$urandom_range(4)]
                                       : $urandom_range(192000, 8000));
      repeat (80) pending_words.push_back(rand_word());
      drain();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
